// ----- hdl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the sorted key table blocks.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_IN_W = 64;
  localparam int INDEX_W  = 8;
  localparam int HANDLE_W = 32;
  localparam int MODE_W   = 16;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_LOOKUP   = 2'd1,
    REQ_SET_MODE = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_OVERWRITTEN = 3'd1,
    ST_REJECTED    = 3'd2,
    ST_FULL        = 3'd3,
    ST_FOUND       = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_CLEARED     = 3'd6
  } status_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [KEY_IN_W-1:0]   key;
    logic [HANDLE_W-1:0]   handle;
    logic [MODE_W-1:0]     mode_value;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [INDEX_W-1:0]    index;
    logic [HANDLE_W-1:0]   found_handle;
    logic [MODE_W-1:0]     old_mode;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [HANDLE_W-1:0]   handle;
    logic [MODE_W-1:0]     mode;
  } entry_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    entry_t                wdata;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_CHECK,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

// ----- hdl/sorted_key_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_binary_search
// Key table kept in sorted order in one RAM, searched by binary search.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready  skt_pkg::req_t
//  out_     output     out_valid/out_ready  skt_pkg::rsp_t
//  cfg_     input      cfg_we               cfg_wdata (overwrite enable)
//
//  one transaction at a time; the table RAM has one read and one write port
//  search probes read the middle entry, then compare it; clear skips search
//  insert moves each entry up (read, then write), then writes the new entry
//  the result moves to an output register, so the next transaction can start
//  synchronous active-low reset empties the table, no clearing pass
//  out_ready low holds the result; the sequencer waits only for the next one
// ----------------------------------------------------------------------------
module sorted_key_table_binary_search (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  skt_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output skt_pkg::rsp_t out_data
);

  skt_pkg::mem_req_t mem_ctl;
  skt_pkg::entry_t   mem_rdata;
  skt_pkg::rsp_t     res_data;
  skt_pkg::rsp_t     out_data_r;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_ctl   (mem_ctl),
    .mem_rdata (mem_rdata)
  );

  skt_ram #(
    .ADDR_W (skt_pkg::IDX_W),
    .DATA_W ($bits(skt_pkg::entry_t))
  ) u_ram (
    .clk   (clk),
    .we    (mem_ctl.we),
    .waddr (mem_ctl.waddr),
    .wdata (mem_ctl.wdata),
    .raddr (mem_ctl.raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !res_valid)
    else $error("transaction accepted while a result is pending");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("pending result changed before transfer");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid && out_data == $past(res_data))
    else $error("result did not reach the output register");

  a_clear_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == skt_pkg::ST_CLEARED |->
      out_data.index == '0 && out_data.found_handle == '0 && out_data.old_mode == '0)
    else $error("clear result carries nonzero fields");

endmodule

// ----- hdl/skt_ram.sv -----
// ----------------------------------------------------------------------------
// skt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 112
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Binary search, insert shift and entry update sequencer over the table RAM.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  skt_pkg::req_t     in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output skt_pkg::rsp_t     res_data,
  output skt_pkg::mem_req_t mem_ctl,
  input  skt_pkg::entry_t   mem_rdata
);

  skt_pkg::state_t               state_r, state_nxt;
  skt_pkg::req_t                 req_r;
  skt_pkg::rsp_t                 res_r;
  logic [skt_pkg::CNT_W-1:0]     count_r;
  logic [skt_pkg::CNT_W-1:0]     lo_r;
  logic [skt_pkg::CNT_W-1:0]     hi_r;
  logic [skt_pkg::CNT_W-1:0]     j_r;
  logic                          ovr_r;
  logic                          hit_r;
  logic [skt_pkg::HANDLE_W-1:0]  fh_r;
  logic [skt_pkg::MODE_W-1:0]    om_r;

  logic [skt_pkg::CNT_W-1:0]     mid;
  logic [skt_pkg::CNT_W-1:0]     j_dec;
  logic [skt_pkg::KEY_BITS-1:0]  req_key;
  logic                          is_full;
  logic                          do_insert;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign j_dec     = j_r - skt_pkg::CNT_W'(1);
  assign req_key   = req_r.key[skt_pkg::KEY_BITS-1:0];
  assign is_full   = (count_r == skt_pkg::CNT_W'(skt_pkg::CAPACITY));
  assign do_insert = (req_r.req_type == skt_pkg::REQ_ADD) && !hit_r && !is_full;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type == skt_pkg::REQ_CLEAR) ? skt_pkg::S_DECIDE
                                                                : skt_pkg::S_SEARCH;
        end
      end
      skt_pkg::S_SEARCH: begin
        if (lo_r < hi_r) begin
          state_nxt = skt_pkg::S_CMP;
        end else if (lo_r < count_r) begin
          state_nxt = skt_pkg::S_CHECK;
        end else begin
          state_nxt = skt_pkg::S_DECIDE;
        end
      end
      skt_pkg::S_CMP:      state_nxt = skt_pkg::S_SEARCH;
      skt_pkg::S_CHECK:    state_nxt = skt_pkg::S_DECIDE;
      skt_pkg::S_DECIDE: begin
        state_nxt = do_insert ? skt_pkg::S_SHIFT_RD : skt_pkg::S_DONE;
      end
      skt_pkg::S_SHIFT_RD: begin
        state_nxt = (j_r > lo_r) ? skt_pkg::S_SHIFT_WR : skt_pkg::S_DONE;
      end
      skt_pkg::S_SHIFT_WR: state_nxt = skt_pkg::S_SHIFT_RD;
      skt_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = skt_pkg::S_IDLE;
        end
      end
      default:             state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_ctl   = '0;
    unique case (state_r)
      skt_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      skt_pkg::S_SEARCH: begin
        mem_ctl.raddr = (lo_r < hi_r) ? mid[skt_pkg::IDX_W-1:0]
                                      : lo_r[skt_pkg::IDX_W-1:0];
      end
      skt_pkg::S_DECIDE: begin
        mem_ctl.waddr     = lo_r[skt_pkg::IDX_W-1:0];
        mem_ctl.wdata.key = req_key;
        if (req_r.req_type == skt_pkg::REQ_ADD && hit_r && ovr_r) begin
          mem_ctl.we           = 1'b1;
          mem_ctl.wdata.handle = req_r.handle;
          mem_ctl.wdata.mode   = req_r.mode_value;
        end else if (req_r.req_type == skt_pkg::REQ_SET_MODE && hit_r) begin
          mem_ctl.we           = 1'b1;
          mem_ctl.wdata.handle = fh_r;
          mem_ctl.wdata.mode   = req_r.mode_value;
        end
      end
      skt_pkg::S_SHIFT_RD: begin
        mem_ctl.raddr = j_dec[skt_pkg::IDX_W-1:0];
        if (j_r <= lo_r) begin
          mem_ctl.we           = 1'b1;
          mem_ctl.waddr        = lo_r[skt_pkg::IDX_W-1:0];
          mem_ctl.wdata.key    = req_key;
          mem_ctl.wdata.handle = req_r.handle;
          mem_ctl.wdata.mode   = req_r.mode_value;
        end
      end
      skt_pkg::S_SHIFT_WR: begin
        mem_ctl.we    = 1'b1;
        mem_ctl.waddr = j_r[skt_pkg::IDX_W-1:0];
        mem_ctl.wdata = mem_rdata;
      end
      skt_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res_data = res_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skt_pkg::S_IDLE;
      count_r <= '0;
      ovr_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        ovr_r <= cfg_wdata;
      end
      if (state_r == skt_pkg::S_DECIDE && req_r.req_type == skt_pkg::REQ_CLEAR) begin
        count_r <= '0;
        ovr_r   <= 1'b1;
      end
      if (state_r == skt_pkg::S_SHIFT_RD && j_r <= lo_r) begin
        count_r <= count_r + skt_pkg::CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_valid) begin
          req_r <= in_data;
          lo_r  <= '0;
          hi_r  <= count_r;
          hit_r <= 1'b0;
          fh_r  <= '0;
          om_r  <= '0;
        end
      end
      skt_pkg::S_CMP: begin
        if (mem_rdata.key < req_key) begin
          lo_r <= mid + skt_pkg::CNT_W'(1);
        end else begin
          hi_r <= mid;
        end
      end
      skt_pkg::S_CHECK: begin
        hit_r <= (mem_rdata.key == req_key);
        fh_r  <= mem_rdata.handle;
        om_r  <= mem_rdata.mode;
      end
      skt_pkg::S_DECIDE: begin
        j_r                <= count_r;
        res_r              <= '0;
        res_r.status       <= skt_pkg::ST_NOT_FOUND;
        case (req_r.req_type)
          skt_pkg::REQ_CLEAR: begin
            res_r.status <= skt_pkg::ST_CLEARED;
          end
          skt_pkg::REQ_ADD: begin
            if (hit_r) begin
              res_r.index  <= skt_pkg::INDEX_W'(lo_r);
              res_r.status <= ovr_r ? skt_pkg::ST_OVERWRITTEN : skt_pkg::ST_REJECTED;
            end else if (is_full) begin
              res_r.status <= skt_pkg::ST_FULL;
            end else begin
              res_r.index  <= skt_pkg::INDEX_W'(lo_r);
              res_r.status <= skt_pkg::ST_INSERTED;
            end
          end
          default: begin
            if (hit_r) begin
              res_r.status       <= skt_pkg::ST_FOUND;
              res_r.index        <= skt_pkg::INDEX_W'(lo_r);
              res_r.found_handle <= fh_r;
              res_r.old_mode     <= om_r;
            end
          end
        endcase
      end
      skt_pkg::S_SHIFT_WR: begin
        j_r <= j_dec;
      end
      default: begin
        j_r <= j_r;
      end
    endcase
  end

endmodule
